[src/mtsm_pkg.sv]
// Shared types and constants for the multi-tone sample mixer.
// No dependencies; imported by mtsm_cell and multi_tone_sample_mixer.
`timescale 1ns / 1ps

package mtsm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int LEVEL_W    = 16;
  localparam int MAG_W      = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MAX_TONES  = 4;

  // Register map: steps first, then levels, one register per tone.
  localparam logic [CFG_IDX_W-1:0] REG_TONE0_STEP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TONE0_LEVEL = 3'd4;

  // Fixed-point constants for building the quarter-wave sine table.
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] SINE_SCALE  = 64'd32767;
  localparam int          TAYLOR_TERMS = 6;
  localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
    64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6
  };

  // What travels from one tone cell to the next.
  typedef struct packed {
    logic                valid;
    logic                restart;
    logic [SAMPLE_W-1:0] sum;
  } link_t;

  // Decoded register write for one cell.
  typedef struct packed {
    logic                  step_we;
    logic                  level_we;
    logic [CFG_DATA_W-1:0] data;
  } cfg_t;

endpackage

[src/mtsm_cell.sv]
// One tone cell: phase accumulator, sine ROM, level multiply and running-sum add.
// Depends on mtsm_pkg; instantiated in a chain by multi_tone_sample_mixer.
`timescale 1ns / 1ps

module mtsm_cell #(
  parameter int PHASE_BITS = 32,
  parameter int TABLE_BITS = 10
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  mtsm_pkg::cfg_t cfg,
  input  mtsm_pkg::link_t link_in,
  output mtsm_pkg::link_t link_out
);
  import mtsm_pkg::*;

  localparam int QUARTER_LEN = 1 << TABLE_BITS;
  localparam int ADDR_W      = TABLE_BITS + 1;
  localparam int IDX_SHIFT   = PHASE_BITS - 2 - TABLE_BITS;
  localparam int PROD_W      = LEVEL_W + MAG_W;

  typedef logic [MAG_W-1:0] rom_t [0:QUARTER_LEN];

  // Quarter-wave table: Q30 Horner evaluation of the sine Taylor series,
  // rounded to a 32767 scale. Evaluated once at elaboration.
  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] e;
    logic [63:0] sub;
    for (int k = 0; k <= QUARTER_LEN; k++) begin
      x  = (64'(k) * HALF_PI_Q30) >> TABLE_BITS;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      for (int d = 0; d < TAYLOR_TERMS; d++) begin
        sub = ((x2 * t) >> 30) / TAYLOR_DIV[d];
        t   = (sub >= Q30_ONE) ? 64'd0 : Q30_ONE - sub;
      end
      s = (x * t) >> 30;
      e = (s * SINE_SCALE + (Q30_ONE >> 1)) >> 30;
      if (e > SINE_SCALE) begin
        e = SINE_SCALE;
      end
      r[k] = e[MAG_W-1:0];
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [PHASE_BITS-1:0] step;
  logic [LEVEL_W-1:0]    level;
  logic [PHASE_BITS-1:0] phase;

  logic [PHASE_BITS-1:0] phase_used;
  logic [1:0]            quad;
  logic [TABLE_BITS-1:0] idx_raw;
  logic [ADDR_W-1:0]     addr;

  logic                a_valid;
  logic                a_restart;
  logic                a_neg;
  logic [SAMPLE_W-1:0] a_sum;
  logic [MAG_W-1:0]    mag;

  logic [PROD_W-1:0]   prod;
  logic [SAMPLE_W-1:0] contrib;
  logic [SAMPLE_W-1:0] sum_next;

  // The restart flag rides with the item, so every cell clears its phase
  // exactly when the first sample of a buffer reaches it.
  always_comb begin
    phase_used = link_in.restart ? '0 : phase;
    quad       = phase_used[PHASE_BITS-1 -: 2];
    idx_raw    = phase_used[IDX_SHIFT +: TABLE_BITS];
    if (quad[0]) begin
      addr = ADDR_W'(QUARTER_LEN) - {1'b0, idx_raw};
    end else begin
      addr = {1'b0, idx_raw};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step  <= PHASE_BITS'(1);
      level <= '0;
    end else begin
      if (cfg.step_we) begin
        step <= cfg.data[PHASE_BITS-1:0];
      end
      if (cfg.level_we) begin
        level <= cfg.data[LEVEL_W-1:0];
      end
    end
  end

  // Lookup stage: phase advance and registered ROM read.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= '0;
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= link_in.valid;
      if (link_in.valid) begin
        phase <= phase_used + step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_restart <= link_in.restart;
      a_neg     <= quad[1];
      a_sum     <= link_in.sum;
      mag       <= SINE_ROM[addr];
    end
  end

  // Scale stage: level times sine, truncated, added to or subtracted from the running sum.
  always_comb begin
    prod    = PROD_W'(level) * PROD_W'(mag);
    contrib = prod[PROD_W-1 -: SAMPLE_W];
    if (a_neg) begin
      sum_next = a_sum - contrib;
    end else begin
      sum_next = a_sum + contrib;
    end
  end

  // Only the valid flag needs a reset; the payload follows it.
  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.valid <= 1'b0;
    end else if (advance) begin
      link_out.valid <= a_valid;
    end
    if (advance) begin
      link_out.restart <= a_restart;
      link_out.sum     <= sum_next;
    end
  end

endmodule

[src/multi_tone_sample_mixer.sv]
// Top level of the multi-tone sample mixer: stream ports, register decode, cell chain.
// Depends on mtsm_pkg and mtsm_cell.
`timescale 1ns / 1ps

// The mixer adds up to TONES sine tones to a stream of signed 16-bit mono
// samples. Each tone is a direct digital synthesizer whose phase advances by
// its step register once per sample; its level (Q1.15, 32768 is full scale,
// 0 mutes it) scales a quarter-wave sine lookup, and the sum wraps modulo
// 2^16. A request with the restart flag set in tuser clears all phases before
// that sample is mixed. The tones sit in a chain of identical cells, one per
// tone, and each sample walks down the chain picking up one tone per cell.
// Throughput is one sample per clock cycle while no stall holds the chain.
// Each cell registers a sine ROM read, then the level multiply and sum. The
// output register only holds the pipeline when a finished sample is waiting
// and m_tready is low. Registers are written with cfg_we, cfg_index and
// cfg_data: indexes 0 to 3 are the tone steps, 4 to 7 the tone levels; write
// them only while no request is in flight.

module multi_tone_sample_mixer #(
  parameter int TONES      = 4,
  parameter int TABLE_BITS = 10,
  parameter int PHASE_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Slave side.
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [mtsm_pkg::SAMPLE_W-1:0]        s_tdata,   // [15:0] sample_in
  input  logic [0:0]                           s_tuser,   // [0] restart
  // Master side.
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [mtsm_pkg::SAMPLE_W-1:0]        m_tdata,   // [15:0] sample_out
  // Register write port.
  input  logic                                 cfg_we,
  input  logic [mtsm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mtsm_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import mtsm_pkg::*;

  link_t link [TONES+1];
  cfg_t  cell_cfg [TONES];
  logic  advance;

  // The whole chain moves together; it only stops when the last cell holds a
  // result that the downstream side has not taken yet.
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  assign link[0].valid   = s_tvalid;
  assign link[0].restart = s_tuser[0];
  assign link[0].sum     = s_tdata;

  for (genvar i = 0; i < TONES; i++) begin : g_tone
    // Writes to tones beyond TONES match no cell and are dropped.
    always_comb begin
      cell_cfg[i].step_we  = cfg_we && (cfg_index == REG_TONE0_STEP + CFG_IDX_W'(i));
      cell_cfg[i].level_we = cfg_we && (cfg_index == REG_TONE0_LEVEL + CFG_IDX_W'(i));
      cell_cfg[i].data     = cfg_data;
    end

    mtsm_cell #(
      .PHASE_BITS (PHASE_BITS),
      .TABLE_BITS (TABLE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .cfg      (cell_cfg[i]),
      .link_in  (link[i]),
      .link_out (link[i+1])
    );
  end

  // The last cell's output register doubles as the master-side register.
  assign m_tvalid = link[TONES].valid;
  assign m_tdata  = link[TONES].sum;

endmodule
